### hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while in reset
`define ASSERT_NOW(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("%m: check failed");

// next-cycle implication, quiet while in reset
`define ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("%m: check failed");

// state right after a reset cycle
`define ASSERT_RESET(lbl, b) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (b)) \
    else $error("%m: reset check failed");

`endif

### hw/rtl/qapc_pkg.sv
package qapc_pkg;

  localparam int FRAC_BITS = 14;

  localparam int QW      = 16;
  localparam int GW      = 16;
  localparam int ERR_W   = 18;
  localparam int RATE_W  = 32;
  localparam int PROD_W  = 2 * QW;
  localparam int SUM_W   = PROD_W + 2;
  localparam int EN_W    = SUM_W + 1;
  localparam int N_STAGES = 5;

  // twice a value with 28 fraction bits down to FRAC_BITS fraction bits
  localparam int TWICE_S = 2 * (QW - 2) - 1 - FRAC_BITS;
  localparam int TW_RSH  = (TWICE_S > 0) ? TWICE_S : 0;
  localparam int TW_LSH  = (TWICE_S < 0) ? -TWICE_S : 0;
  localparam int TW_W    = EN_W + 1 + TW_LSH;
  localparam longint TW_RND = (TW_RSH > 0) ? (64'sd1 <<< (TW_RSH - 1)) : 64'sd0;

  // gain is q8.8
  localparam int GAIN_SH = 8;
  localparam int GP_W    = ERR_W + GW + 1;
  localparam longint GAIN_RND = 64'sd1 <<< (GAIN_SH - 1);

  localparam logic signed [ERR_W-1:0]  ERR_MAX  = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0]  ERR_MIN  = {1'b1, {(ERR_W-1){1'b0}}};
  localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
  localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

  localparam int IN_TDATA_W  = 8 * QW;
  localparam int OUT_FIELDS_W = 3 * ERR_W + 3 * RATE_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_GAIN_ROLL  = 2'd0;
  localparam logic [1:0] REG_GAIN_PITCH = 2'd1;
  localparam logic [1:0] REG_GAIN_YAW   = 2'd2;

  localparam logic [GW-1:0] GAIN_RESET = GW'(1024);

  typedef logic signed [QW-1:0]    qcomp_t;
  typedef logic signed [SUM_W-1:0] esum_t;

  typedef struct packed {
    qcomp_t z;
    qcomp_t y;
    qcomp_t x;
    qcomp_t w;
  } quat_t;

  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

endpackage

### hw/rtl/quaternion_attitude_p_controller.sv
// an accepted input beat moves through the product, sum, error, gain and rate registers to its output beat
// throughput: one beat per cycle while out_tready is high, set by the five-stage multiply pipeline
// a stalled output holds the pipeline back stage by stage, bubbles are filled
// reset (rst_n low, synchronous) empties the pipeline and sets all gains to 4.0
// there is no clearing pass, the block accepts beats the cycle after reset
module quaternion_attitude_p_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // target_w, target_x, target_y, target_z, measured_w, measured_x, measured_y, measured_z
  input  logic [qapc_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // angle_err_x, angle_err_y, angle_err_z, rate_cmd_x, rate_cmd_y, rate_cmd_z, zero pad
  output logic [qapc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [qapc_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [qapc_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [qapc_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                             cfg_pready
);
  import qapc_pkg::*;

  logic [N_STAGES-1:0] v_r;
  logic [N_STAGES-1:0] v_nxt;
  logic [N_STAGES:0]   rdy;
  logic [N_STAGES-1:0] v_prev;

  logic [GW-1:0] gain_r [3];
  logic          cfg_wr;
  logic [1:0]    cfg_idx;

  quat_t     target;
  quat_t     measured;
  stage_en_t en;
  logic      err_neg;
  esum_t     err_vec [3];

  logic signed [EN_W-1:0]   en_v    [3];
  logic signed [TW_W-1:0]   tw_v    [3];
  logic signed [ERR_W-1:0]  err_nxt [3];
  logic signed [ERR_W-1:0]  err_r   [3];
  logic signed [ERR_W-1:0]  err4_r  [3];
  logic signed [ERR_W-1:0]  err5_r  [3];
  logic signed [GP_W-1:0]   gp_nxt  [3];
  logic signed [GP_W-1:0]   gp_r    [3];
  logic signed [GP_W-1:0]   rs_v    [3];
  logic signed [RATE_W-1:0] rate_nxt [3];
  logic signed [RATE_W-1:0] rate_r   [3];

  // ---------------- configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        gain_r[a] <= GAIN_RESET;
      end
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GAIN_ROLL:  gain_r[0] <= cfg_pwdata[GW-1:0];
        REG_GAIN_PITCH: gain_r[1] <= cfg_pwdata[GW-1:0];
        REG_GAIN_YAW:   gain_r[2] <= cfg_pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GAIN_ROLL:  cfg_prdata = CFG_DW'(gain_r[0]);
      REG_GAIN_PITCH: cfg_prdata = CFG_DW'(gain_r[1]);
      REG_GAIN_YAW:   cfg_prdata = CFG_DW'(gain_r[2]);
      default:        cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline control
  // a stage loads when it is empty or its contents move on this cycle
  always_comb begin
    rdy[N_STAGES] = out_tready;
    for (int k = N_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign v_prev = {v_r[N_STAGES-2:0], in_tvalid};

  always_comb begin
    for (int k = 0; k < N_STAGES; k++) begin
      v_nxt[k] = rdy[k] ? v_prev[k] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready = rdy[0];
  assign en.s1     = rdy[0];
  assign en.s2     = rdy[1];

  // ---------------- stages 1 and 2: error quaternion
  assign target.w   = in_tdata[1*QW-1:0*QW];
  assign target.x   = in_tdata[2*QW-1:1*QW];
  assign target.y   = in_tdata[3*QW-1:2*QW];
  assign target.z   = in_tdata[4*QW-1:3*QW];
  assign measured.w = in_tdata[5*QW-1:4*QW];
  assign measured.x = in_tdata[6*QW-1:5*QW];
  assign measured.y = in_tdata[7*QW-1:6*QW];
  assign measured.z = in_tdata[8*QW-1:7*QW];

  qapc_err_quat u_err_quat (
    .clk      (clk),
    .en       (en),
    .target   (target),
    .measured (measured),
    .err_neg  (err_neg),
    .err_vec  (err_vec)
  );

  // ---------------- stage 3: shortest path, doubling, rounding, clamp
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      en_v[a] = err_neg ? -EN_W'(err_vec[a]) : EN_W'(err_vec[a]);
      tw_v[a] = ((TW_W'(en_v[a]) + TW_W'(TW_RND)) >>> TW_RSH) <<< TW_LSH;
      if (tw_v[a] > TW_W'(ERR_MAX)) begin
        err_nxt[a] = ERR_MAX;
      end else if (tw_v[a] < TW_W'(ERR_MIN)) begin
        err_nxt[a] = ERR_MIN;
      end else begin
        err_nxt[a] = tw_v[a][ERR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      err_r <= err_nxt;
    end
  end

  // ---------------- stage 4: gain multiply
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      gp_nxt[a] = GP_W'(err_r[a]) * $signed({1'b0, gain_r[a]});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      gp_r   <= gp_nxt;
      err4_r <= err_r;
    end
  end

  // ---------------- stage 5: back to FRAC_BITS, clamp, output register
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rs_v[a] = (gp_r[a] + GP_W'(GAIN_RND)) >>> GAIN_SH;
      if (rs_v[a] > GP_W'(RATE_MAX)) begin
        rate_nxt[a] = RATE_MAX;
      end else if (rs_v[a] < GP_W'(RATE_MIN)) begin
        rate_nxt[a] = RATE_MIN;
      end else begin
        rate_nxt[a] = rs_v[a][RATE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      rate_r <= rate_nxt;
      err5_r <= err4_r;
    end
  end

  assign out_tvalid = v_r[N_STAGES-1];
  assign out_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                       rate_r[2], rate_r[1], rate_r[0],
                       err5_r[2], err5_r[1], err5_r[0]};

  // ---------------- checks
`include "assert_macros.svh"

  // gains are unsigned, so a rate never flips the sign of its angle error
  `ASSERT_NOW(a_rate_sign, out_tvalid && !err5_r[0][ERR_W-1], !rate_r[0][RATE_W-1])
  `ASSERT_NEXT(a_gain_wr, cfg_wr && (cfg_idx == REG_GAIN_ROLL), gain_r[0] == $past(cfg_pwdata[GW-1:0]))
  `ASSERT_NEXT(a_stall_hold, v_r[2] && !rdy[3], v_r[2] && $stable(err_r[0]))
  `ASSERT_RESET(a_rst_empty, !out_tvalid && in_tready)

endmodule

### hw/rtl/qapc_err_quat.sv
module qapc_err_quat (
  input  logic              clk,
  input  qapc_pkg::stage_en_t en,
  input  qapc_pkg::quat_t   target,
  input  qapc_pkg::quat_t   measured,
  output logic              err_neg,
  output qapc_pkg::esum_t   err_vec [3]
);
  import qapc_pkg::*;

  qcomp_t mc [4];
  qcomp_t tc [4];
  logic signed [PROD_W-1:0] prod_nxt [16];
  logic signed [PROD_W-1:0] prod_r   [16];
  esum_t e0_nxt;
  esum_t evec_nxt [3];
  esum_t evec_r   [3];
  logic  neg_r;

  assign mc[0] = measured.w;
  assign mc[1] = measured.x;
  assign mc[2] = measured.y;
  assign mc[3] = measured.z;
  assign tc[0] = target.w;
  assign tc[1] = target.x;
  assign tc[2] = target.y;
  assign tc[3] = target.z;

  // all sixteen partial products, m component i times t component j
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_nxt[i*4+j] = PROD_W'($signed(mc[i]) * $signed(tc[j]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int k = 0; k < 16; k++) begin
        prod_r[k] <= prod_nxt[k];
      end
    end
  end

  // conj(m) times t
  always_comb begin
    e0_nxt = SUM_W'(prod_r[0]) + SUM_W'(prod_r[5]) + SUM_W'(prod_r[10])
           + SUM_W'(prod_r[15]);
    evec_nxt[0] = SUM_W'(prod_r[1]) - SUM_W'(prod_r[4]) - SUM_W'(prod_r[11])
                + SUM_W'(prod_r[14]);
    evec_nxt[1] = SUM_W'(prod_r[2]) + SUM_W'(prod_r[7]) - SUM_W'(prod_r[8])
                - SUM_W'(prod_r[13]);
    evec_nxt[2] = SUM_W'(prod_r[3]) - SUM_W'(prod_r[6]) + SUM_W'(prod_r[9])
                - SUM_W'(prod_r[12]);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      neg_r <= e0_nxt[SUM_W-1];
      for (int a = 0; a < 3; a++) begin
        evec_r[a] <= evec_nxt[a];
      end
    end
  end

  assign err_neg = neg_r;
  assign err_vec = evec_r;

endmodule
